// File: design/ttcg_pkg.sv
// Package for the text-to-character-grid layout block.
// Holds request and register codes, reset values and the structs shared by
// the controller and the top level. Depends on nothing.
package ttcg_pkg;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_LINE_WIDTH = 2'd0,
        CFG_GRID_CELLS = 2'd1,
        CFG_FILL_CHAR  = 2'd2,
        CFG_COMBINE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_BYTE,
        ST_RDATA
    } t_state;

    localparam logic [7:0] FULL_STOP  = 8'h2E;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    localparam logic [7:0] LINE_WIDTH_RST = 8'd20;
    localparam logic [8:0] GRID_CELLS_RST = 9'd256;
    localparam logic [7:0] FILL_CHAR_RST  = 8'd32;
    localparam logic       COMBINE_RST    = 1'b1;

    typedef struct packed {
        logic [7:0] line_width;
        logic [8:0] grid_cells;
        logic [7:0] fill_char;
        logic       combine_stop_enable;
    } t_cfg;

    typedef struct packed {
        logic       char_we;
        logic       flag_we;
        logic [7:0] char_wdata;
        logic       flag_wdata;
    } t_mem_wr;

endpackage

// File: design/ttcg_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on nothing.
module ttcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ttcg_ctrl.sv
// Layout controller: request sequencing, clear sweeps, layout position and
// the memory write and read controls. Depends on ttcg_pkg.
module ttcg_ctrl #(
    parameter int MAX_CELLS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttcg_pkg::t_cfg               i_cfg,
    input  logic                         i_accept,
    input  logic [1:0]                   i_req_type,
    input  logic [7:0]                   i_text_byte,
    input  logic [7:0]                   i_cell_addr,
    input  logic [7:0]                   i_rd_char,
    input  logic                         i_rd_flag,
    output ttcg_pkg::t_mem_wr            o_wr,
    output logic [$clog2(MAX_CELLS)-1:0] o_waddr,
    output logic [$clog2(MAX_CELLS)-1:0] o_raddr,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic                         o_status,
    output logic [7:0]                   o_cell_char,
    output logic                         o_cell_stop_flag
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);

    ttcg_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [8:0]    r_idx, n_idx;
    logic [7:0]    r_col, n_col;
    logic [7:0]    r_prev, n_prev;
    logic          r_first, n_first;
    logic          r_ended, n_ended;
    logic [7:0]    r_byte, n_byte;
    logic          r_rd_oob, n_rd_oob;
    logic          r_valid, n_valid;
    logic          r_status, n_status;
    logic [7:0]    r_char, n_char;
    logic          r_flag, n_flag;

    ttcg_pkg::t_req w_req;
    logic [8:0]     w_limit;
    logic           w_last_init;
    logic           w_last_clr;
    logic [8:0]     w_idx_p1;
    logic [8:0]     w_idx_m1;
    logic [7:0]     w_col_p1;
    logic [7:0]     w_col_adv;
    logic [7:0]     w_steps;
    logic [9:0]     w_nl_sum;

    assign w_req = ttcg_pkg::t_req'(i_req_type);

    // Cells in use: the lesser of grid_cells and the store depth.
    assign w_limit = (32'(i_cfg.grid_cells) < MAX_CELLS) ? i_cfg.grid_cells
                                                          : 9'(MAX_CELLS);

    assign w_last_init = (32'(r_cnt) == MAX_CELLS - 1);
    assign w_last_clr  = ((32'(r_cnt) + 1) >= 32'(w_limit));

    assign w_idx_p1  = r_idx + 9'd1;
    assign w_idx_m1  = r_idx - 9'd1;
    assign w_col_p1  = r_col + 8'd1;
    assign w_col_adv = (w_col_p1 >= i_cfg.line_width) ? 8'd0 : w_col_p1;

    // A newline skips the rest of the row in one step; reaching the end of
    // the cells in use anywhere along the way ends the text.
    assign w_steps  = (r_col < i_cfg.line_width) ? (i_cfg.line_width - r_col) : 8'd0;
    assign w_nl_sum = {1'b0, r_idx} + {2'b00, w_steps};

    assign o_raddr = AW'(i_cell_addr);
    assign o_busy  = (r_state != ttcg_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ttcg_pkg::ST_INIT: begin
                if (w_last_init) begin
                    n_state = ttcg_pkg::ST_IDLE;
                end
            end
            ttcg_pkg::ST_IDLE: begin
                if (i_accept) begin
                    case (w_req)
                        ttcg_pkg::REQ_START: begin
                            n_state = (w_limit == 9'd0) ? ttcg_pkg::ST_IDLE
                                                        : ttcg_pkg::ST_CLEAR;
                        end
                        ttcg_pkg::REQ_BYTE: n_state = ttcg_pkg::ST_BYTE;
                        ttcg_pkg::REQ_READ: n_state = ttcg_pkg::ST_RDATA;
                        default:            n_state = ttcg_pkg::ST_IDLE;
                    endcase
                end
            end
            ttcg_pkg::ST_CLEAR: begin
                if (w_last_clr) begin
                    n_state = ttcg_pkg::ST_IDLE;
                end
            end
            ttcg_pkg::ST_BYTE:  n_state = ttcg_pkg::ST_IDLE;
            ttcg_pkg::ST_RDATA: n_state = ttcg_pkg::ST_IDLE;
            default:            n_state = ttcg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_col    = r_col;
        n_prev   = r_prev;
        n_first  = r_first;
        n_ended  = r_ended;
        n_byte   = r_byte;
        n_rd_oob = r_rd_oob;
        n_valid  = 1'b0;
        n_status = r_status;
        n_char   = r_char;
        n_flag   = r_flag;
        o_wr     = '0;
        o_waddr  = '0;

        case (r_state)
            ttcg_pkg::ST_INIT: begin
                o_wr.char_we    = 1'b1;
                o_wr.flag_we    = 1'b1;
                o_wr.char_wdata = ttcg_pkg::FILL_CHAR_RST;
                o_wr.flag_wdata = 1'b0;
                o_waddr         = AW'(r_cnt);
                n_cnt           = w_last_init ? '0 : r_cnt + CW'(1);
            end
            ttcg_pkg::ST_IDLE: begin
                if (i_accept) begin
                    n_byte   = i_text_byte;
                    n_rd_oob = !(32'(i_cell_addr) < MAX_CELLS);
                    case (w_req)
                        ttcg_pkg::REQ_START: begin
                            n_cnt   = '0;
                            n_idx   = '0;
                            n_col   = '0;
                            n_prev  = '0;
                            n_first = 1'b1;
                            n_ended = 1'b0;
                            if (w_limit == 9'd0) begin
                                n_valid  = 1'b1;
                                n_status = 1'b0;
                                n_char   = '0;
                                n_flag   = 1'b0;
                            end
                        end
                        ttcg_pkg::REQ_BYTE: begin
                        end
                        ttcg_pkg::REQ_READ: begin
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = r_ended;
                            n_char   = '0;
                            n_flag   = 1'b0;
                        end
                    endcase
                end
            end
            ttcg_pkg::ST_CLEAR: begin
                o_wr.char_we    = 1'b1;
                o_wr.flag_we    = 1'b1;
                o_wr.char_wdata = i_cfg.fill_char;
                o_wr.flag_wdata = 1'b0;
                o_waddr         = AW'(r_cnt);
                n_cnt           = r_cnt + CW'(1);
                if (w_last_clr) begin
                    n_valid  = 1'b1;
                    n_status = 1'b0;
                    n_char   = '0;
                    n_flag   = 1'b0;
                end
            end
            ttcg_pkg::ST_BYTE: begin
                if (!r_ended) begin
                    n_prev  = r_byte;
                    n_first = 1'b0;
                    if (r_byte == ttcg_pkg::NUL_BYTE) begin
                        n_ended = 1'b1;
                    end else if (i_cfg.combine_stop_enable &&
                                 (r_byte == ttcg_pkg::FULL_STOP)) begin
                        if (r_first || (r_prev == ttcg_pkg::FULL_STOP)) begin
                            // The full stop takes a cell of its own, flagged.
                            if (r_idx < w_limit) begin
                                o_wr.flag_we    = 1'b1;
                                o_wr.flag_wdata = 1'b1;
                                o_waddr         = AW'(r_idx);
                                n_idx           = w_idx_p1;
                                n_col           = w_col_adv;
                            end else begin
                                n_ended = 1'b1;
                            end
                        end else begin
                            // Merge into the flag of the cell before.
                            if ((r_idx != 9'd0) && (w_idx_m1 < w_limit)) begin
                                o_wr.flag_we    = 1'b1;
                                o_wr.flag_wdata = 1'b1;
                                o_waddr         = AW'(w_idx_m1);
                            end
                            if (r_idx >= w_limit) begin
                                n_ended = 1'b1;
                            end
                        end
                    end else if (r_byte == ttcg_pkg::NEWLINE) begin
                        if (w_nl_sum >= {1'b0, w_limit}) begin
                            n_ended = 1'b1;
                        end else begin
                            n_idx = w_nl_sum[8:0];
                            n_col = '0;
                        end
                    end else begin
                        if (r_idx >= w_limit) begin
                            n_ended = 1'b1;
                        end else begin
                            o_wr.char_we    = 1'b1;
                            o_wr.char_wdata = r_byte;
                            o_waddr         = AW'(r_idx);
                            n_idx           = w_idx_p1;
                            n_col           = w_col_adv;
                        end
                    end
                end
                n_valid  = 1'b1;
                n_status = n_ended;
                n_char   = '0;
                n_flag   = 1'b0;
            end
            ttcg_pkg::ST_RDATA: begin
                n_valid  = 1'b1;
                n_status = r_ended;
                n_char   = r_rd_oob ? 8'd0 : i_rd_char;
                n_flag   = r_rd_oob ? 1'b0 : i_rd_flag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttcg_pkg::ST_INIT;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_col   <= '0;
            r_prev  <= '0;
            r_first <= 1'b1;
            r_ended <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_prev  <= n_prev;
            r_first <= n_first;
            r_ended <= n_ended;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_rd_oob <= n_rd_oob;
        r_status <= n_status;
        r_char   <= n_char;
        r_flag   <= n_flag;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_cell_char      = r_char;
    assign o_cell_stop_flag = r_flag;

endmodule

// File: design/text_to_character_grid_layout.sv
// Top level of the text-to-character-grid layout block: configuration
// registers, the character and stop-flag memories and the layout controller.
// Depends on ttcg_pkg, ttcg_ram and ttcg_ctrl.
//
//   Channel   Signals                                        Handshake
//   request   i_req_type, i_text_byte, i_cell_addr           start & !busy
//   result    o_status, o_cell_char, o_cell_stop_flag        o_valid, one cycle
//   config    i_cfg_index, i_cfg_data                        i_cfg_valid & o_cfg_ready
//
// After reset the block sweeps both memories to their reset contents with
// busy high. A text byte or a read passes through its own working state;
// a start runs a clear sweep over each cell in use through the memory write
// port. The result word appears on the cycle after the last working cycle
// and cannot be stalled. Configuration is always ready.
module text_to_character_grid_layout #(
    parameter int MAX_CELLS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_text_byte,
    input  logic [7:0] i_cell_addr,
    output logic       o_valid,
    output logic       o_status,
    output logic [7:0] o_cell_char,
    output logic       o_cell_stop_flag,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);

    ttcg_pkg::t_cfg    r_cfg;
    ttcg_pkg::t_mem_wr w_wr;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [7:0]        w_rd_char;
    logic              w_rd_flag;
    logic              w_busy;
    logic              w_accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_busy;
    assign w_accept    = start && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width          <= ttcg_pkg::LINE_WIDTH_RST;
            r_cfg.grid_cells          <= ttcg_pkg::GRID_CELLS_RST;
            r_cfg.fill_char           <= ttcg_pkg::FILL_CHAR_RST;
            r_cfg.combine_stop_enable <= ttcg_pkg::COMBINE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ttcg_pkg::t_cfg_idx'(i_cfg_index))
                ttcg_pkg::CFG_LINE_WIDTH: r_cfg.line_width <= i_cfg_data[7:0];
                ttcg_pkg::CFG_GRID_CELLS: r_cfg.grid_cells <= i_cfg_data;
                ttcg_pkg::CFG_FILL_CHAR:  r_cfg.fill_char  <= i_cfg_data[7:0];
                ttcg_pkg::CFG_COMBINE:    r_cfg.combine_stop_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ttcg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.char_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr.char_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_char)
    );

    ttcg_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.flag_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr.flag_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_flag)
    );

    ttcg_ctrl #(
        .MAX_CELLS (MAX_CELLS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (w_accept),
        .i_req_type       (i_req_type),
        .i_text_byte      (i_text_byte),
        .i_cell_addr      (i_cell_addr),
        .i_rd_char        (w_rd_char),
        .i_rd_flag        (w_rd_flag),
        .o_wr             (w_wr),
        .o_waddr          (w_waddr),
        .o_raddr          (w_raddr),
        .o_busy           (w_busy),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_cell_char      (o_cell_char),
        .o_cell_stop_flag (o_cell_stop_flag)
    );

endmodule
